// File: hw/rtl/madf_pkg.sv
// shared types and constants for the multi-converter deserializer and framer
package madf_pkg;

	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] FPP_RESET = 11'd1024;

	localparam logic [7:0] START_MARK = 8'hFF;
	localparam logic [7:0] MARK_SUB   = 8'hFE;

	localparam int USER_W      = 2;
	localparam int USER_MARKER = 0;
	localparam int USER_PEND   = 1;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_marker;
		logic       last_of_run;
		logic       packet_end;
	} beat_t;

endpackage

// File: hw/rtl/madf_lane.sv
// one converter lane: serial-to-parallel shift and sample-to-byte conversion
module madf_lane import madf_pkg::*; #(
	parameter int SAMPLE_BITS = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift_en,
	input  logic       din,
	output logic [7:0] sample_byte
);

	logic [SAMPLE_BITS-2:0] shift_q;
	logic [SAMPLE_BITS-1:0] word;
	logic [SAMPLE_BITS+7:0] word_ext;
	logic [7:0]             low_byte;

	// every word is fully shifted in before use, so no clear is needed between words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= '0;
		end else if (shift_en) begin
			shift_q <= word[SAMPLE_BITS-2:0];
		end
	end

	always_comb begin
		word     = {shift_q, din};
		word_ext = {8'd0, word};
		low_byte = word_ext[7:0];
		// negative samples become zero, 255 is reserved for the start marker
		if (word[SAMPLE_BITS-1]) begin
			sample_byte = 8'd0;
		end else if (low_byte == START_MARK) begin
			sample_byte = MARK_SUB;
		end else begin
			sample_byte = low_byte;
		end
	end

endmodule

// File: hw/rtl/madf_merge.sv
// frame merge: captures lane bytes, inserts start marker, counts frames, output register
module madf_merge import madf_pkg::*; #(
	parameter int CHANNELS   = 4,
	parameter int MAX_FRAMES = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic [CHANNELS-1:0][7:0] sample_bytes,
	input  logic [CFG_W-1:0]         frames_per_packet,
	input  logic                     out_ready,
	output logic                     take_ok,
	output logic                     out_valid,
	output beat_t                    out_beat
);

	localparam int FC_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int LEN_A = $clog2(MAX_FRAMES + 1);
	localparam int LEN_W = (LEN_A > CFG_W) ? LEN_A : CFG_W;
	localparam int CNT_W = $clog2(CHANNELS + 1);

	logic [FC_W-1:0]            fc_q;
	logic                       mark_q;
	logic [CNT_W-1:0]           left_q;
	logic [CHANNELS-1:0][7:0]   bytes_q;
	logic                       closes_q;
	logic                       out_valid_q;
	beat_t                      beat_q;

	logic [LEN_W-1:0] cfg_ext;
	logic [LEN_W-1:0] plen;
	logic             opens;
	logic             closes;
	logic             busy;
	logic             out_free;
	logic             emit;
	logic             last_byte;
	beat_t            cur_beat;

	always_comb begin
		cfg_ext = LEN_W'(frames_per_packet);
		// zero acts as one, anything above the maximum acts as the maximum
		priority if (cfg_ext == '0) begin
			plen = LEN_W'(1);
		end else if (cfg_ext > LEN_W'(MAX_FRAMES)) begin
			plen = LEN_W'(MAX_FRAMES);
		end else begin
			plen = cfg_ext;
		end
		opens  = (fc_q == '0);
		closes = (LEN_W'(fc_q) + LEN_W'(1)) >= plen;

		busy      = mark_q || (left_q != '0);
		out_free  = !out_valid_q || out_ready;
		emit      = busy && out_free;
		last_byte = !mark_q && (left_q == CNT_W'(1));
		take_ok   = !busy || (emit && last_byte);

		cur_beat.out_byte    = mark_q ? START_MARK : bytes_q[0];
		cur_beat.is_marker   = mark_q;
		cur_beat.last_of_run = last_byte;
		cur_beat.packet_end  = last_byte && closes_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q        <= '0;
			mark_q      <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				mark_q <= opens;
				left_q <= CNT_W'(CHANNELS);
				fc_q   <= closes ? '0 : fc_q + FC_W'(1);
			end else if (emit) begin
				if (mark_q) begin
					mark_q <= 1'b0;
				end else begin
					left_q <= left_q - CNT_W'(1);
				end
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	// frame bytes shift toward slot 0 as they leave
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= sample_bytes;
			closes_q <= closes;
		end else if (emit && !mark_q) begin
			for (int i = 0; i < CHANNELS - 1; i++) begin
				bytes_q[i] <= bytes_q[i+1];
			end
		end
		if (emit) begin
			beat_q <= cur_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = beat_q;

endmodule

// File: hw/rtl/multi_adc_deserializer_framer.sv
// top level: serial converter deserializer with start-marker packet framing
// Takes one bit slot per cycle on s_axis (one bit per converter, first bit of a
// word is the MSB). Every SAMPLE_BITS slots a word completes in each of the
// CHANNELS lanes and the merge stage sends CHANNELS bytes on m_axis, one byte per
// cycle while m_axis_tready is high, preceded by a 0xFF start marker on the first
// frame of each packet. Negative samples give 0 and 255 is sent as 254. The input
// is taken every cycle except on the slot that completes a word while bytes of
// the previous frame are still queued; with SAMPLE_BITS >= CHANNELS + 1 and
// m_axis always ready this never happens, so the sustained rate is one slot per
// cycle, and the output byte register is what sets the pace otherwise. Bytes
// pass the merge frame registers, then the output byte register. frames_per_packet
// (cfg) is taken as is; 0 acts as 1, values above MAX_FRAMES act as MAX_FRAMES.
module multi_adc_deserializer_framer import madf_pkg::*; #(
	parameter int CHANNELS    = 4,
	parameter int SAMPLE_BITS = 9,
	parameter int MAX_FRAMES  = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// adc0_bit, adc1_bit, ... one bit each from bit 0, zero padded
	input  logic [((CHANNELS + 7) / 8) * 8-1:0] s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// out_byte
	output logic [7:0]                         m_axis_tdata,
	output logic                               m_axis_tlast,
	// is_marker, packet_end
	output logic [USER_W-1:0]                  m_axis_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [CFG_W-1:0]                   cfg_data
);

	localparam int BP_W = $clog2(SAMPLE_BITS);

	logic [BP_W-1:0]            bitpos_q;
	logic [CFG_W-1:0]           fpp_q;
	logic                       word_end;
	logic                       take_ok;
	logic                       accept;
	logic                       word_fire;
	logic [CHANNELS-1:0][7:0]   lane_bytes;
	beat_t                      beat;

	assign word_end      = (bitpos_q == BP_W'(SAMPLE_BITS - 1));
	assign s_axis_tready = !word_end || take_ok;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign word_fire     = accept && word_end;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitpos_q <= '0;
			fpp_q    <= FPP_RESET;
		end else begin
			if (accept) begin
				bitpos_q <= word_end ? '0 : bitpos_q + BP_W'(1);
			end
			if (cfg_valid) begin
				fpp_q <= cfg_data;
			end
		end
	end

	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		madf_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (accept),
			.din        (s_axis_tdata[g]),
			.sample_byte(lane_bytes[g])
		);
	end

	madf_merge #(
		.CHANNELS  (CHANNELS),
		.MAX_FRAMES(MAX_FRAMES)
	) u_merge (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (word_fire),
		.sample_bytes     (lane_bytes),
		.frames_per_packet(fpp_q),
		.out_ready        (m_axis_tready),
		.take_ok          (take_ok),
		.out_valid        (m_axis_tvalid),
		.out_beat         (beat)
	);

	assign m_axis_tdata              = beat.out_byte;
	assign m_axis_tlast              = beat.last_of_run;
	assign m_axis_tuser[USER_MARKER] = beat.is_marker;
	assign m_axis_tuser[USER_PEND]   = beat.packet_end;

`ifndef SYNTHESIS
	a_marker_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USER_MARKER] |->
			m_axis_tdata == START_MARK && !m_axis_tlast && !m_axis_tuser[USER_PEND])
		else $error("start marker request malformed");

	a_no_ff_sample: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[USER_MARKER] |-> m_axis_tdata != START_MARK)
		else $error("sample byte equals start marker");

	a_pend_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[USER_PEND] |-> m_axis_tlast)
		else $error("packet end on a byte that is not last of its run");

	a_stall_word_end: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> word_end)
		else $error("input stalled away from a word boundary");
`endif

endmodule

// File: tb/tb_multi_adc_deserializer_framer.sv
// testbench for the multi-converter deserializer and start-marker framer
module tb_multi_adc_deserializer_framer;
	import madf_pkg::*;

	localparam int NCH         = 4;
	localparam int SBITS       = 9;
	localparam int MAXF        = 1024;
	localparam int RAND_SLOTS  = 400;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic                  wr;
		logic [CFG_W-1:0]      fpp;
		logic [NCH-1:0][SBITS-1:0] smp;   // channel 3 first
		logic                  pin;
		logic [NCH-1:0][7:0]   bytes;
	} word_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	// adc0_bit, adc1_bit, adc2_bit, adc3_bit, zero padded
	logic [7:0]       s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	// out_byte
	logic [7:0]       m_axis_tdata;
	logic             m_axis_tlast;
	// is_marker, packet_end
	logic [USER_W-1:0] m_axis_tuser;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	// predictor state
	logic [3:0]           slot_idx = '0;
	logic [SBITS-1:0]     lane_word [NCH];
	logic [9:0]           frame_idx = '0;
	logic [CFG_W-1:0]     fpp_reg = FPP_RESET;
	beat_t                beats_due [$];

	int src_idle_pct = 34;
	int dst_idle_pct = 62;
	int slots_sent   = 0;
	int beats_seen   = 0;
	int packets_seen = 0;
	int cfg_writes   = 0;
	int mismatches   = 0;
	int cycle_cnt    = 0;

	word_row_t directed_rows [3];

	multi_adc_deserializer_framer #(
		.CHANNELS(NCH),
		.SAMPLE_BITS(SBITS),
		.MAX_FRAMES(MAXF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still due", cycle_cnt,
				beats_due.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// shift one bit slot into the lanes and queue the bytes of a finished frame
	task automatic take_slot(input logic [NCH-1:0] bits, input logic pin,
			input logic [NCH-1:0][7:0] pinned);
		int unsigned plen;
		logic opens;
		logic closes;
		logic [SBITS-1:0] s;
		beat_t b;
		for (int c = 0; c < NCH; c++)
			lane_word[c] = {lane_word[c][SBITS-2:0], bits[c]};
		slot_idx = slot_idx + 4'd1;
		if (slot_idx < SBITS)
			return;
		slot_idx = '0;
		plen = (fpp_reg == 0) ? 1 : ((fpp_reg > MAXF) ? MAXF : fpp_reg);
		opens = (frame_idx == 0);
		closes = (frame_idx + 1 >= plen);
		if (opens) begin
			b.out_byte = START_MARK;
			b.is_marker = 1'b1;
			b.last_of_run = 1'b0;
			b.packet_end = 1'b0;
			beats_due.push_back(b);
		end
		for (int c = 0; c < NCH; c++) begin
			s = lane_word[c];
			// sign bit set means a negative sample, sent as zero
			if (s[SBITS-1])
				s = '0;
			b.out_byte = s[7:0];
			if (b.out_byte == START_MARK)
				b.out_byte = MARK_SUB;
			if (pin)
				b.out_byte = pinned[c];
			b.is_marker = 1'b0;
			b.last_of_run = (c == NCH - 1);
			b.packet_end = (c == NCH - 1) && closes;
			beats_due.push_back(b);
			lane_word[c] = '0;
		end
		frame_idx = closes ? 10'd0 : frame_idx + 10'd1;
	endtask

	task automatic send_slot(input logic [NCH-1:0] bits, input logic pin,
			input logic [NCH-1:0][7:0] pinned);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(8 - NCH){1'b0}}, bits};
		do @(posedge clk); while (!s_axis_tready);
		take_slot(bits, pin, pinned);
		slots_sent++;
		if (slots_sent == 150) begin
			src_idle_pct = 62;
			dst_idle_pct = 34;
		end else if (slots_sent == 300) begin
			src_idle_pct = 0;
			dst_idle_pct = 0;
		end
	endtask

	// register writes only once every queued byte is out
	task automatic write_fpp(input logic [CFG_W-1:0] v);
		s_axis_tvalid <= 1'b0;
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		fpp_reg = v;
		cfg_writes++;
	endtask

	always @(posedge clk) begin : rx_check
		beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_seen++;
			if (m_axis_tuser[USER_PEND])
				packets_seen++;
			if (beats_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected byte %0h last %0b user %0b", m_axis_tdata,
						m_axis_tlast, m_axis_tuser);
			end else begin
				want = beats_due.pop_front();
				if (want.out_byte !== m_axis_tdata
						|| want.is_marker !== m_axis_tuser[USER_MARKER]
						|| want.last_of_run !== m_axis_tlast
						|| want.packet_end !== m_axis_tuser[USER_PEND]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("byte %0d: expected %0h/%0b/%0b/%0b got %0h/%0b/%0b/%0b",
							beats_seen, want.out_byte, want.is_marker, want.last_of_run,
							want.packet_end, m_axis_tdata, m_axis_tuser[USER_MARKER],
							m_axis_tlast, m_axis_tuser[USER_PEND]);
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
	end

	initial begin
		logic [NCH-1:0] bits;
		logic [SBITS-1:0] gen_word [NCH];
		logic [CFG_W-1:0] v;
		int rnd_slots;
		int phase;
		int n;
		int fixed_fpp [6];

		rnd_slots = 0;
		phase = 0;
		fixed_fpp = '{2, 1024, 1, 3, 1025, 0};
		for (int c = 0; c < NCH; c++) begin
			lane_word[c] = '0;
			gen_word[c] = '0;
		end

		// zero, negative (minus one), 255 clamp, 254 kept
		directed_rows[0] = '{1'b0, 11'd0, {9'h0FE, 9'h0FF, 9'h1FF, 9'h000}, 1'b1,
			{8'hFE, 8'hFE, 8'h00, 8'h00}};
		// length 0 acts as 1 and lands mid-packet, so this frame closes it
		directed_rows[1] = '{1'b1, 11'd0, {9'h07F, 9'h080, 9'h001, 9'h100}, 1'b1,
			{8'h7F, 8'h80, 8'h01, 8'h00}};
		// length above the maximum, new packet opens with a marker
		directed_rows[2] = '{1'b1, 11'd2047, {9'h0FD, 9'h1AA, 9'h055, 9'h0AA}, 1'b1,
			{8'hFD, 8'h00, 8'h55, 8'hAA}};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 3; r++) begin
			if (directed_rows[r].wr)
				write_fpp(directed_rows[r].fpp);
			for (int k = 0; k < SBITS; k++) begin
				for (int c = 0; c < NCH; c++)
					bits[c] = directed_rows[r].smp[c][SBITS-1-k];
				send_slot(bits, directed_rows[r].pin, directed_rows[r].bytes);
			end
		end

		// random phases, each with its own packet length, not aligned to words
		while (rnd_slots < RAND_SLOTS) begin
			if (phase < 6) begin
				v = 11'(fixed_fpp[phase]);
			end else begin
				case ($urandom_range(0, 9))
					0: v = 11'd0;
					1: v = 11'd1024;
					2: v = 11'd2047;
					3: v = 11'($urandom_range(0, 2047));
					default: v = 11'($urandom_range(1, 6));
				endcase
			end
			write_fpp(v);
			n = $urandom_range(18, 60);
			repeat (n) begin
				if (slot_idx == 0) begin
					for (int c = 0; c < NCH; c++) begin
						case ($urandom_range(0, 9))
							0: gen_word[c] = 9'h000;
							1: gen_word[c] = 9'h1FF;
							2: gen_word[c] = 9'h0FF;
							3: gen_word[c] = 9'h0FE;
							4: gen_word[c] = 9'h100;
							default: gen_word[c] = 9'($urandom_range(0, 511));
						endcase
					end
				end
				for (int c = 0; c < NCH; c++)
					bits[c] = gen_word[c][SBITS-1-slot_idx];
				send_slot(bits, 1'b0, '0);
				rnd_slots++;
			end
			phase++;
		end
		s_axis_tvalid <= 1'b0;

		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d bit slots over %0d packet length settings", slots_sent,
			cfg_writes + 1);
		$display("checked %0d bytes, %0d packet ends, %0d mismatches", beats_seen,
			packets_seen, mismatches);
		if (mismatches == 0 && beats_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
